// File: sv/assert_macros.svh
// Assertion macros used by the queue RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/mhpq_pkg.sv
// Shared types and constants for the max-priority queue.
// No dependencies.
package mhpq_pkg;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W      = $clog2(DEPTH);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                         kind;
    logic signed [DATA_WIDTH-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] popped_value;
    logic [1:0]                   status;
    logic [CNT_W-1:0]             count_after;
  } out_rsp_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic                         push;
    logic                         pop;
    logic signed [DATA_WIDTH-1:0] value;
    logic [CNT_W-1:0]             count;
  } cell_ctl_t;

endpackage

// File: sv/mhpq_cell.sv
// One slot of the sorted row: holds one entry, kept in descending order.
// Depends on mhpq_pkg.
module mhpq_cell import mhpq_pkg::*; (
  input  logic                         clk_i,
  input  logic [IDX_W-1:0]             idx_i,
  input  cell_ctl_t                    ctl_i,
  input  logic signed [DATA_WIDTH-1:0] left_val_i,
  input  logic                         left_ge_i,
  input  logic signed [DATA_WIDTH-1:0] right_val_i,
  output logic signed [DATA_WIDTH-1:0] val_o,
  output logic                         ge_o
);

  logic signed [DATA_WIDTH-1:0] val_q, val_d;
  logic                         occupied;

  assign occupied = CNT_W'(idx_i) < ctl_i.count;
  // Occupied and not below the new value: this slot stays put on a push.
  assign ge_o     = occupied && (val_q >= ctl_i.value);
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.push) begin
      if (!ge_o) begin
        val_d = left_ge_i ? ctl_i.value : left_val_i;
      end
    end else if (ctl_i.pop) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: sv/max_heap_priority_queue.sv
// Max-priority queue of signed 32-bit entries.
// Requests come in on in_req_i under in_valid_i/in_stall_o: kind push stores value,
// kind pop removes the largest entry held. Each request yields exactly one response
// on out_rsp_o under out_valid_o/out_stall_i: popped_value (0 unless a pop succeeded),
// status (ok, overflow on a push to a full queue, underflow on a pop of an empty one)
// and count_after, the number of entries held afterwards.
// Storage is a row of DEPTH cells kept in descending order; every request is applied to
// all cells at once, each cell taking its own value, the new value or a neighbor's.
// The response is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while in_stall_o is low.
// The response sits in an output register; a new request is taken in the same cycle the
// held response is taken, so in_stall_o is high only while out_valid_o is high and the
// receiver stalls. A stalled response holds its value.
// Reset empties the queue at once (count cleared, no clearing pass) and drops any
// pending response. Entries equal in value are indistinguishable.
`include "assert_macros.svh"

module max_heap_priority_queue import mhpq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  logic signed [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic                         cell_ge  [DEPTH];

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_rsp_t         out_q, out_d;

  logic      accept, full, empty, push_ok, pop_ok;
  cell_ctl_t ctl;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = count_q == CNT_W'(DEPTH);
  assign empty      = count_q == '0;
  assign push_ok    = accept && (in_req_i.kind == KIND_PUSH) && !full;
  assign pop_ok     = accept && (in_req_i.kind == KIND_POP) && !empty;

  assign ctl.push  = push_ok;
  assign ctl.pop   = pop_ok;
  assign ctl.value = in_req_i.value;
  assign ctl.count = count_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_val, right_val;
    logic                         left_ge;
    if (k == 0) begin : g_head
      assign left_val = '0;
      assign left_ge  = 1'b1;
    end else begin : g_mid
      assign left_val = cell_val[k-1];
      assign left_ge  = cell_ge[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_body
      assign right_val = cell_val[k+1];
    end
    mhpq_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(k)),
      .ctl_i       (ctl),
      .left_val_i  (left_val),
      .left_ge_i   (left_ge),
      .right_val_i (right_val),
      .val_o       (cell_val[k]),
      .ge_o        (cell_ge[k])
    );
  end

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_d.popped_value = pop_ok ? cell_val[0] : '0;
    out_d.count_after  = count_d;
    out_d.status       = ST_OK;
    case (in_req_i.kind)
      KIND_PUSH: if (full)  out_d.status = ST_OVERFLOW;
      KIND_POP:  if (empty) out_d.status = ST_UNDERFLOW;
      default:   out_d.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `ASSERT_CLK(a_overflow_keeps,
    (accept && in_req_i.kind == KIND_PUSH && full) |=>
    (out_q.status == ST_OVERFLOW && count_q == $past(count_q)),
    "overflow changed state")
  `ASSERT_CLK(a_pop_count,
    pop_ok |=> (count_q == $past(count_q) - 1'b1 && out_q.count_after == count_q),
    "pop count mismatch")
  `ASSERT_CLK(a_head_order,
    (count_q >= CNT_W'(2)) |-> (cell_val[0] >= cell_val[1]),
    "head out of order")

endmodule
